### sv/led_blink_pattern_sequencer_top_macros.svh
// ============================================================================
// LED blink pattern sequencer: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ============================================================================
`ifndef LED_BLINK_PATTERN_SEQUENCER_TOP_MACROS_SVH
`define LED_BLINK_PATTERN_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication
`define LBPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/lbps_pkg.sv
// ============================================================================
// lbps_pkg
// Types and constants shared by the LED blink pattern sequencer.
// ============================================================================
package lbps_pkg;

    localparam int REQ_TYPE_W  = 3;
    localparam int MODE_W      = 3;
    localparam int DUR_W       = 32;
    localparam int COUNT_W     = 8;
    localparam int SYM_IDX_W   = 4;
    localparam int SYM_CODE_W  = 2;
    localparam int PLEN_W      = 5;
    localparam int PERIOD_W    = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int SYM_SLOTS   = 16;

    localparam logic [PERIOD_W-1:0] SLOW_RST = 16'd1000;
    localparam logic [PERIOD_W-1:0] MID_RST  = 16'd500;
    localparam logic [PERIOD_W-1:0] FAST_RST = 16'd200;
    localparam logic [PERIOD_W-1:0] DASH_RST = 16'd600;
    localparam logic [PERIOD_W-1:0] DOT_RST  = 16'd200;
    localparam logic [PERIOD_W-1:0] GAP_RST  = 16'd500;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_TICK          = 3'd0,
        REQ_SET_MODE      = 3'd1,
        REQ_DELAY_MODE    = 3'd2,
        REQ_COUNTED       = 3'd3,
        REQ_START_PATTERN = 3'd4,
        REQ_WRITE_SYMBOL  = 3'd5
    } req_code_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF     = 3'd0,
        MODE_ON      = 3'd1,
        MODE_SLOW    = 3'd2,
        MODE_MID     = 3'd3,
        MODE_FAST    = 3'd4,
        MODE_PATTERN = 3'd5,
        MODE_COUNTED = 3'd6
    } mode_t;

    typedef enum logic [SYM_CODE_W-1:0] {
        SYM_GAP  = 2'd0,
        SYM_DOT  = 2'd1,
        SYM_DASH = 2'd2
    } sym_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOW_PERIOD = 3'd0,
        CFG_MID_PERIOD  = 3'd1,
        CFG_FAST_PERIOD = 3'd2,
        CFG_DASH_TIME   = 3'd3,
        CFG_DOT_TIME    = 3'd4,
        CFG_GAP_CYCLE   = 3'd5,
        CFG_ACTIVE_LOW  = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic [MODE_W-1:0]     mode_code;
        logic [DUR_W-1:0]      duration;
        logic [COUNT_W-1:0]    count;
        logic [SYM_IDX_W-1:0]  symbol_index;
        logic [SYM_CODE_W-1:0] symbol_code;
        logic [PLEN_W-1:0]     pattern_len;
    } req_t;

    typedef struct packed {
        logic              pin_level;
        logic              led_lit;
        logic              toggled;
        logic              sequence_done;
        logic [MODE_W-1:0] mode_now;
    } rsp_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] slow_period;
        logic [PERIOD_W-1:0] mid_period;
        logic [PERIOD_W-1:0] fast_period;
        logic [PERIOD_W-1:0] dash_time;
        logic [PERIOD_W-1:0] dot_time;
        logic [PERIOD_W-1:0] gap_cycle;
        logic                active_low;
    } cfg_t;

    typedef struct packed {
        logic                  en;
        logic [SYM_IDX_W-1:0]  idx;
        logic [SYM_CODE_W-1:0] code;
    } sym_wr_t;

endpackage

### sv/lbps_req_if.sv
// ============================================================================
// lbps_req_if
// Request channel: valid/ready handshake with the command and tick fields.
// ============================================================================
interface lbps_req_if;
    logic                              valid;
    logic                              ready;
    logic [lbps_pkg::REQ_TYPE_W-1:0]   req_type;
    logic [lbps_pkg::MODE_W-1:0]       mode_code;
    logic [lbps_pkg::DUR_W-1:0]        duration;
    logic [lbps_pkg::COUNT_W-1:0]      count;
    logic [lbps_pkg::SYM_IDX_W-1:0]    symbol_index;
    logic [lbps_pkg::SYM_CODE_W-1:0]   symbol_code;
    logic [lbps_pkg::PLEN_W-1:0]       pattern_len;

    modport source (
        output valid, req_type, mode_code, duration, count, symbol_index,
               symbol_code, pattern_len,
        input  ready
    );

    modport sink (
        input  valid, req_type, mode_code, duration, count, symbol_index,
               symbol_code, pattern_len,
        output ready
    );
endinterface

### sv/lbps_rsp_if.sv
// ============================================================================
// lbps_rsp_if
// Result channel: valid/ready handshake with the LED status fields.
// ============================================================================
interface lbps_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        pin_level;
    logic                        led_lit;
    logic                        toggled;
    logic                        sequence_done;
    logic [lbps_pkg::MODE_W-1:0] mode_now;

    modport source (
        output valid, pin_level, led_lit, toggled, sequence_done, mode_now,
        input  ready
    );

    modport sink (
        input  valid, pin_level, led_lit, toggled, sequence_done, mode_now,
        output ready
    );
endinterface

### sv/led_blink_pattern_sequencer_top.sv
// ----------------------------------------------------------------------------
// Usage: commands and millisecond ticks arrive on the req channel, one
// transaction per item; every accepted item returns exactly one status
// transaction on rsp (pin level, lit state, toggle and done events, mode).
// Timing registers and pin polarity are written through cfg_we/cfg_index/
// cfg_data while the block is idle; writes take effect on the next edge.
// An accepted item is held in the input register and is processed by the engine
// once the result register can take it; its result is then offered from the
// result register until rsp takes it.
// Throughput: one item per cycle while rsp is not stalled, as the engine does
// the whole state update (tick add, due compare, next-due add) at once.
// Backpressure: when rsp is stalled the result register holds, the input
// register fills, and req.ready drops only once both are occupied.
// Reset: rst_n clears the LED state to off, clears pending delays and loads
// the default timing values; the symbol store keeps no reset value.
// ----------------------------------------------------------------------------
// ============================================================================
// led_blink_pattern_sequencer_top
// One LED channel sequencer: input register, engine, result register.
// ============================================================================
module led_blink_pattern_sequencer_top
#(
    parameter int PATTERN_DEPTH = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    lbps_req_if.sink                         req,
    lbps_rsp_if.source                       rsp,
    input  logic                             cfg_we,
    input  logic [lbps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lbps_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic                            in_valid_reg, in_valid_next;
    lbps_pkg::req_t                  in_data_reg;
    logic                            out_valid_reg, out_valid_next;
    lbps_pkg::rsp_t                  out_data_reg;

    logic                            advance;
    logic                            fire;
    lbps_pkg::req_t                  req_data;
    lbps_pkg::rsp_t                  eng_rsp;
    lbps_pkg::cfg_t                  cfg;
    lbps_pkg::sym_wr_t               sym_wr;
    logic [lbps_pkg::PLEN_W-1:0]     rd_pos;
    logic [lbps_pkg::SYM_CODE_W-1:0] rd_code;

    assign advance   = !out_valid_reg || rsp.ready;
    assign fire      = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;

    assign req_data.req_type     = req.req_type;
    assign req_data.mode_code    = req.mode_code;
    assign req_data.duration     = req.duration;
    assign req_data.count        = req.count;
    assign req_data.symbol_index = req.symbol_index;
    assign req_data.symbol_code  = req.symbol_code;
    assign req_data.pattern_len  = req.pattern_len;

    assign in_valid_next  = req.ready ? req.valid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_data_reg <= req_data;
        end
        if (fire)
        begin
            out_data_reg <= eng_rsp;
        end
    end

    lbps_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lbps_store #(
        .PATTERN_DEPTH (PATTERN_DEPTH)
    ) u_store
    (
        .clk     (clk),
        .sym_wr  (sym_wr),
        .rd_pos  (rd_pos),
        .rd_code (rd_code)
    );

    lbps_engine #(
        .PATTERN_DEPTH (PATTERN_DEPTH)
    ) u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .req     (in_data_reg),
        .cfg     (cfg),
        .rd_code (rd_code),
        .rd_pos  (rd_pos),
        .sym_wr  (sym_wr),
        .rsp     (eng_rsp)
    );

    assign rsp.valid         = out_valid_reg;
    assign rsp.pin_level     = out_data_reg.pin_level;
    assign rsp.led_lit       = out_data_reg.led_lit;
    assign rsp.toggled       = out_data_reg.toggled;
    assign rsp.sequence_done = out_data_reg.sequence_done;
    assign rsp.mode_now      = out_data_reg.mode_now;

endmodule

### sv/lbps_cfg.sv
// ============================================================================
// lbps_cfg
// Configuration register file: timing values and pin polarity.
// ============================================================================
module lbps_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lbps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lbps_pkg::CFG_DATA_W-1:0]  cfg_data,
    output lbps_pkg::cfg_t                   cfg
);

    lbps_pkg::cfg_t cfg_reg;
    lbps_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                lbps_pkg::CFG_SLOW_PERIOD: cfg_next.slow_period = cfg_data;
                lbps_pkg::CFG_MID_PERIOD:  cfg_next.mid_period  = cfg_data;
                lbps_pkg::CFG_FAST_PERIOD: cfg_next.fast_period = cfg_data;
                lbps_pkg::CFG_DASH_TIME:   cfg_next.dash_time   = cfg_data;
                lbps_pkg::CFG_DOT_TIME:    cfg_next.dot_time    = cfg_data;
                lbps_pkg::CFG_GAP_CYCLE:   cfg_next.gap_cycle   = cfg_data;
                lbps_pkg::CFG_ACTIVE_LOW:  cfg_next.active_low  = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slow_period <= lbps_pkg::SLOW_RST;
            cfg_reg.mid_period  <= lbps_pkg::MID_RST;
            cfg_reg.fast_period <= lbps_pkg::FAST_RST;
            cfg_reg.dash_time   <= lbps_pkg::DASH_RST;
            cfg_reg.dot_time    <= lbps_pkg::DOT_RST;
            cfg_reg.gap_cycle   <= lbps_pkg::GAP_RST;
            cfg_reg.active_low  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/lbps_store.sv
// ============================================================================
// lbps_store
// Pattern symbol store: one write port, one combinational read port.
// ============================================================================
module lbps_store
#(
    parameter int PATTERN_DEPTH = 16
)
(
    input  logic                              clk,
    input  lbps_pkg::sym_wr_t                 sym_wr,
    input  logic [lbps_pkg::PLEN_W-1:0]       rd_pos,
    output logic [lbps_pkg::SYM_CODE_W-1:0]   rd_code
);

    // only the first slots are reachable by a write
    localparam int DEPTH = (PATTERN_DEPTH < lbps_pkg::SYM_SLOTS) ?
                           PATTERN_DEPTH : lbps_pkg::SYM_SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [lbps_pkg::SYM_CODE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (sym_wr.en && (32'(sym_wr.idx) < DEPTH))
        begin
            mem[sym_wr.idx[AW-1:0]] <= sym_wr.code;
        end
    end

    always_comb
    begin
        if (32'(rd_pos) < DEPTH)
        begin
            rd_code = mem[rd_pos[AW-1:0]];
        end
        else
        begin
            rd_code = lbps_pkg::SYM_GAP;
        end
    end

endmodule

### sv/lbps_engine.sv
// ============================================================================
// lbps_engine
// LED channel state and the processing of one transaction on each fire.
// ============================================================================
`include "led_blink_pattern_sequencer_top_macros.svh"

module lbps_engine
#(
    parameter int PATTERN_DEPTH = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              fire,
    input  lbps_pkg::req_t                    req,
    input  lbps_pkg::cfg_t                    cfg,
    input  logic [lbps_pkg::SYM_CODE_W-1:0]   rd_code,
    output logic [lbps_pkg::PLEN_W-1:0]       rd_pos,
    output lbps_pkg::sym_wr_t                 sym_wr,
    output lbps_pkg::rsp_t                    rsp
);

    localparam int LEN_CAP_I = (PATTERN_DEPTH > 31) ? 31 : PATTERN_DEPTH;
    localparam logic [lbps_pkg::PLEN_W-1:0] LEN_CAP = lbps_pkg::PLEN_W'(LEN_CAP_I);

    localparam int DW = lbps_pkg::DUR_W;
    localparam int PW = lbps_pkg::PLEN_W;
    localparam int CW = lbps_pkg::COUNT_W;

    logic [DW-1:0]             tick_now_reg, tick_now_next;
    logic [DW-1:0]             next_due_reg, next_due_next;
    logic [DW-1:0]             delay_due_reg, delay_due_next;
    logic                      delay_pending_reg, delay_pending_next;
    logic [lbps_pkg::MODE_W-1:0] pending_mode_reg, pending_mode_next;
    lbps_pkg::mode_t           cur_mode_reg, cur_mode_next;
    logic                      lit_reg, lit_next;
    logic [DW-1:0]             half_period_reg, half_period_next;
    logic [CW-1:0]             blinks_left_reg, blinks_left_next;
    logic [PW-1:0]             play_pos_reg, play_pos_next;
    logic [PW-1:0]             play_len_reg, play_len_next;
    logic [CW-1:0]             repeat_target_reg, repeat_target_next;
    logic [CW-1:0]             repeat_done_reg, repeat_done_next;

    logic                      is_tick, is_pat;
    logic [PW-1:0]             len_sat;
    logic [DW-1:0]             pre_tick, pre_nd;
    lbps_pkg::mode_t           pre_mode;
    logic [PW-1:0]             pre_pos, pre_len;
    logic [CW-1:0]             pre_rdone, pre_rtgt;
    logic                      due;

    lbps_pkg::mode_t           post_mode;
    logic                      post_lit;
    logic [CW-1:0]             post_blinks;
    logic [PW-1:0]             post_pos;
    logic [CW-1:0]             post_rdone;
    logic [DW-1:0]             post_nd;
    logic                      step_tog, step_done;
    logic [DW-1:0]             nd_base, nd_add;
    logic                      nd_upd;
    logic [PW-1:0]             pos_inc;
    logic [CW-1:0]             rdone_inc;

    logic                      apply_en;
    logic [lbps_pkg::MODE_W-1:0] apply_code;
    lbps_pkg::mode_t           apply_mode;

    // ---------------- state before the mode step ----------------
    assign is_tick = fire && (req.req_type == lbps_pkg::REQ_TICK);
    assign is_pat  = fire && (req.req_type == lbps_pkg::REQ_START_PATTERN);
    assign len_sat = (req.pattern_len > LEN_CAP) ? LEN_CAP : req.pattern_len;

    assign pre_tick  = is_tick ? (tick_now_reg + 32'd1) : tick_now_reg;
    assign pre_nd    = is_pat  ? tick_now_reg : next_due_reg;
    assign pre_mode  = is_pat  ? lbps_pkg::MODE_PATTERN : cur_mode_reg;
    assign pre_pos   = is_pat  ? '0 : play_pos_reg;
    assign pre_len   = is_pat  ? len_sat : play_len_reg;
    assign pre_rdone = is_pat  ? '0 : repeat_done_reg;
    assign pre_rtgt  = is_pat  ? req.count : repeat_target_reg;
    assign due       = (is_tick || is_pat) && (pre_tick >= pre_nd);
    assign rd_pos    = pre_pos;

    // ---------------- mode step ----------------
    always_comb
    begin
        post_mode   = pre_mode;
        post_lit    = lit_reg;
        post_blinks = blinks_left_reg;
        post_pos    = pre_pos;
        post_rdone  = pre_rdone;
        step_tog    = 1'b0;
        step_done   = 1'b0;
        nd_base     = pre_nd;
        nd_add      = half_period_reg;
        nd_upd      = 1'b0;
        pos_inc     = pre_pos + PW'(1);
        rdone_inc   = pre_rdone + CW'(1);
        if (due)
        begin
            unique case (pre_mode)
                lbps_pkg::MODE_PATTERN:
                begin
                    if (pre_pos < pre_len)
                    begin
                        nd_base = pre_tick;
                        nd_upd  = 1'b1;
                        unique case (rd_code)
                            lbps_pkg::SYM_DASH:
                            begin
                                post_lit = !lit_reg;
                                step_tog = 1'b1;
                                nd_add   = {16'd0, cfg.dash_time};
                            end
                            lbps_pkg::SYM_DOT:
                            begin
                                post_lit = !lit_reg;
                                step_tog = 1'b1;
                                nd_add   = post_lit ? {16'd0, cfg.dot_time}
                                                    : {15'd0, cfg.dot_time, 1'b0};
                            end
                            default:
                            begin
                                nd_add   = {15'd0, cfg.gap_cycle, 1'b0};
                                post_lit = 1'b0;
                                step_tog = lit_reg;
                            end
                        endcase
                        if (!post_lit)
                        begin
                            if (pos_inc >= pre_len)
                            begin
                                post_pos = '0;
                                if (rdone_inc >= pre_rtgt)
                                begin
                                    post_rdone = '0;
                                    post_mode  = lbps_pkg::MODE_OFF;
                                    step_done  = 1'b1;
                                end
                                else
                                begin
                                    post_rdone = rdone_inc;
                                end
                            end
                            else
                            begin
                                post_pos = pos_inc;
                            end
                        end
                    end
                end
                lbps_pkg::MODE_COUNTED:
                begin
                    if (blinks_left_reg != '0)
                    begin
                        post_lit = !lit_reg;
                        step_tog = 1'b1;
                        nd_upd   = 1'b1;
                        if (!post_lit)
                        begin
                            post_blinks = blinks_left_reg - CW'(1);
                            step_done   = (post_blinks == '0);
                        end
                    end
                end
                lbps_pkg::MODE_SLOW, lbps_pkg::MODE_MID, lbps_pkg::MODE_FAST:
                begin
                    post_lit = !lit_reg;
                    step_tog = 1'b1;
                    nd_upd   = 1'b1;
                end
                default: ;
            endcase
        end
        post_nd = nd_upd ? (nd_base + nd_add) : pre_nd;
    end

    // ---------------- request decode and mode apply ----------------
    always_comb
    begin
        tick_now_next      = tick_now_reg;
        next_due_next      = next_due_reg;
        delay_due_next     = delay_due_reg;
        delay_pending_next = delay_pending_reg;
        pending_mode_next  = pending_mode_reg;
        cur_mode_next      = cur_mode_reg;
        lit_next           = lit_reg;
        half_period_next   = half_period_reg;
        blinks_left_next   = blinks_left_reg;
        play_pos_next      = play_pos_reg;
        play_len_next      = play_len_reg;
        repeat_target_next = repeat_target_reg;
        repeat_done_next   = repeat_done_reg;
        apply_en           = 1'b0;
        apply_code         = req.mode_code;
        sym_wr.en          = 1'b0;
        sym_wr.idx         = req.symbol_index;
        sym_wr.code        = req.symbol_code;

        if (fire)
        begin
            unique case (req.req_type)
                lbps_pkg::REQ_TICK:
                begin
                    tick_now_next    = pre_tick;
                    next_due_next    = post_nd;
                    cur_mode_next    = post_mode;
                    lit_next         = post_lit;
                    blinks_left_next = post_blinks;
                    play_pos_next    = post_pos;
                    repeat_done_next = post_rdone;
                    if (delay_pending_reg && (pre_tick >= delay_due_reg))
                    begin
                        delay_pending_next = 1'b0;
                        delay_due_next     = '0;
                        apply_en           = 1'b1;
                        apply_code         = pending_mode_reg;
                    end
                end
                lbps_pkg::REQ_SET_MODE:
                begin
                    apply_en = 1'b1;
                end
                lbps_pkg::REQ_DELAY_MODE:
                begin
                    pending_mode_next  = req.mode_code;
                    delay_due_next     = tick_now_reg + req.duration;
                    delay_pending_next = 1'b1;
                end
                lbps_pkg::REQ_COUNTED:
                begin
                    half_period_next = req.duration;
                    blinks_left_next = req.count;
                    cur_mode_next    = lbps_pkg::MODE_COUNTED;
                end
                lbps_pkg::REQ_START_PATTERN:
                begin
                    next_due_next      = post_nd;
                    cur_mode_next      = post_mode;
                    lit_next           = post_lit;
                    play_pos_next      = post_pos;
                    play_len_next      = pre_len;
                    repeat_target_next = pre_rtgt;
                    repeat_done_next   = post_rdone;
                end
                lbps_pkg::REQ_WRITE_SYMBOL:
                begin
                    sym_wr.en = (32'(req.symbol_index) < PATTERN_DEPTH);
                end
                default: ;
            endcase
        end

        apply_mode = (apply_code > lbps_pkg::MODE_FAST) ? lbps_pkg::MODE_FAST
                                                         : lbps_pkg::mode_t'(apply_code);
        if (apply_en)
        begin
            cur_mode_next = apply_mode;
            unique case (apply_mode)
                lbps_pkg::MODE_OFF:  lit_next = 1'b0;
                lbps_pkg::MODE_ON:   lit_next = 1'b1;
                lbps_pkg::MODE_SLOW: half_period_next = {16'd0, cfg.slow_period};
                lbps_pkg::MODE_MID:  half_period_next = {16'd0, cfg.mid_period};
                default:             half_period_next = {16'd0, cfg.fast_period};
            endcase
        end

        rsp.pin_level     = lit_next ^ cfg.active_low;
        rsp.led_lit       = lit_next;
        rsp.toggled       = is_tick || is_pat ? step_tog : 1'b0;
        rsp.sequence_done = is_tick || is_pat ? step_done : 1'b0;
        rsp.mode_now      = cur_mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_now_reg      <= '0;
            next_due_reg      <= '0;
            delay_due_reg     <= '0;
            delay_pending_reg <= 1'b0;
            pending_mode_reg  <= lbps_pkg::MODE_OFF;
            cur_mode_reg      <= lbps_pkg::MODE_OFF;
            lit_reg           <= 1'b0;
            half_period_reg   <= '0;
            blinks_left_reg   <= '0;
            play_pos_reg      <= '0;
            play_len_reg      <= '0;
            repeat_target_reg <= '0;
            repeat_done_reg   <= '0;
        end
        else
        begin
            tick_now_reg      <= tick_now_next;
            next_due_reg      <= next_due_next;
            delay_due_reg     <= delay_due_next;
            delay_pending_reg <= delay_pending_next;
            pending_mode_reg  <= pending_mode_next;
            cur_mode_reg      <= cur_mode_next;
            lit_reg           <= lit_next;
            half_period_reg   <= half_period_next;
            blinks_left_reg   <= blinks_left_next;
            play_pos_reg      <= play_pos_next;
            play_len_reg      <= play_len_next;
            repeat_target_reg <= repeat_target_next;
            repeat_done_reg   <= repeat_done_next;
        end
    end

    // ---------------- assertions ----------------
    `LBPS_ASSERT_NOW(a_step_toggle_flips, step_tog, post_lit != lit_reg,
        "step toggle without lit change")
    `LBPS_ASSERT_NOW(a_pos_in_range,
        (cur_mode_reg == lbps_pkg::MODE_PATTERN) && (play_len_reg != '0),
        play_pos_reg < play_len_reg, "pattern position past length")
    `LBPS_ASSERT_NOW(a_len_capped, 1'b1, play_len_reg <= LEN_CAP,
        "pattern length above store depth")
    `LBPS_ASSERT_NEXT(a_idle_holds, !fire,
        $stable(tick_now_reg) && $stable(cur_mode_reg) && $stable(lit_reg),
        "state changed without a transaction")

endmodule

### bench/lbps_sequencer_checker.sv
// ============================================================================
// lbps_sequencer_checker
// Watches the request, result and register ports of the LED sequencer,
// keeps its own copy of the LED state and timing, predicts one status per
// accepted request transaction and compares it field by field in order.
// ============================================================================
module lbps_sequencer_checker
    import lbps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    lbps_req_if                   req,
    lbps_rsp_if                   rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    in_flight,
    output int                    toggles_seen,
    output int                    done_seen
);

    localparam logic [PLEN_W-1:0] DEPTH_LIMIT = PLEN_W'(SYM_SLOTS);

    cfg_t                  timing;
    logic [DUR_W-1:0]      now_tick;
    logic [DUR_W-1:0]      due_tick;
    logic [DUR_W-1:0]      delay_tick;
    logic [DUR_W-1:0]      half_period;
    logic                  delay_armed;
    logic [MODE_W-1:0]     delayed_mode;
    logic [MODE_W-1:0]     mode_q;
    logic                  led_on;
    logic [COUNT_W-1:0]    blinks_rem;
    logic [COUNT_W-1:0]    rep_goal;
    logic [COUNT_W-1:0]    rep_count;
    logic [SYM_CODE_W-1:0] sym_mem [SYM_SLOTS];
    logic [PLEN_W-1:0]     play_idx;
    logic [PLEN_W-1:0]     play_cnt;
    logic                  ev_flip;
    logic                  ev_done;
    rsp_t                  status_q [$];

    function automatic void flip_led();
        led_on  = ~led_on;
        ev_flip = 1'b1;
    endfunction

    function automatic void enter_mode(logic [MODE_W-1:0] m);
        logic [MODE_W-1:0] mm;
        mm = (m > MODE_FAST) ? MODE_FAST : m;
        mode_q = mm;
        case (mm)
            MODE_OFF:  led_on = 1'b0;
            MODE_ON:   led_on = 1'b1;
            MODE_SLOW: half_period = {16'd0, timing.slow_period};
            MODE_MID:  half_period = {16'd0, timing.mid_period};
            default:   half_period = {16'd0, timing.fast_period};
        endcase
    endfunction

    function automatic void advance_mode();
        logic [SYM_CODE_W-1:0] sym;
        if (now_tick < due_tick)
            return;
        if (mode_q == MODE_PATTERN)
        begin
            if (play_idx >= play_cnt)
                return;
            sym = sym_mem[play_idx[SYM_IDX_W-1:0]];
            if (sym == SYM_DASH)
            begin
                flip_led();
                due_tick = now_tick + {16'd0, timing.dash_time};
            end
            else if (sym == SYM_DOT)
            begin
                flip_led();
                due_tick = now_tick + (led_on ? {16'd0, timing.dot_time}
                                              : {15'd0, timing.dot_time, 1'b0});
            end
            else
            begin
                due_tick = now_tick + {15'd0, timing.gap_cycle, 1'b0};
                if (led_on)
                    flip_led();
            end
            if (!led_on)
            begin
                play_idx = play_idx + PLEN_W'(1);
                if (play_idx >= play_cnt)
                begin
                    play_idx  = '0;
                    rep_count = rep_count + COUNT_W'(1);
                    if (rep_count >= rep_goal)
                    begin
                        rep_count = '0;
                        mode_q    = MODE_OFF;
                        ev_done   = 1'b1;
                    end
                end
            end
        end
        else if (mode_q == MODE_COUNTED)
        begin
            if (blinks_rem != '0)
            begin
                flip_led();
                due_tick = due_tick + half_period;
                if (!led_on)
                begin
                    blinks_rem = blinks_rem - COUNT_W'(1);
                    if (blinks_rem == '0)
                    begin
                        led_on  = 1'b0;
                        ev_done = 1'b1;
                    end
                end
            end
        end
        else if (mode_q >= MODE_SLOW && mode_q <= MODE_FAST)
        begin
            flip_led();
            due_tick = due_tick + half_period;
        end
    endfunction

    function automatic rsp_t predict_status(req_t it);
        rsp_t r;
        ev_flip = 1'b0;
        ev_done = 1'b0;
        case (it.req_type)
            REQ_TICK:
            begin
                now_tick = now_tick + DUR_W'(1);
                advance_mode();
                if (delay_armed && now_tick >= delay_tick)
                begin
                    delay_armed = 1'b0;
                    delay_tick  = '0;
                    enter_mode(delayed_mode);
                end
            end
            REQ_SET_MODE:
                enter_mode(it.mode_code);
            REQ_DELAY_MODE:
            begin
                delayed_mode = it.mode_code;
                delay_tick   = now_tick + it.duration;
                delay_armed  = 1'b1;
            end
            REQ_COUNTED:
            begin
                half_period = it.duration;
                blinks_rem  = it.count;
                mode_q      = MODE_COUNTED;
            end
            REQ_START_PATTERN:
            begin
                play_idx  = '0;
                play_cnt  = (it.pattern_len > DEPTH_LIMIT) ? DEPTH_LIMIT : it.pattern_len;
                rep_goal  = it.count;
                rep_count = '0;
                mode_q    = MODE_PATTERN;
                due_tick  = now_tick;
                advance_mode();
            end
            REQ_WRITE_SYMBOL:
                sym_mem[it.symbol_index] = it.symbol_code;
            default: ;
        endcase
        r.pin_level     = led_on ^ timing.active_low;
        r.led_lit       = led_on;
        r.toggled       = ev_flip;
        r.sequence_done = ev_done;
        r.mode_now      = mode_q;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        rsp_t want;
        rsp_t got;
        if (!rst_n)
        begin
            timing       = {SLOW_RST, MID_RST, FAST_RST, DASH_RST, DOT_RST, GAP_RST, 1'b0};
            now_tick     = '0;
            due_tick     = '0;
            delay_tick   = '0;
            half_period  = '0;
            delay_armed  = 1'b0;
            delayed_mode = MODE_OFF;
            mode_q       = MODE_OFF;
            led_on       = 1'b0;
            blinks_rem   = '0;
            rep_goal     = '0;
            rep_count    = '0;
            play_idx     = '0;
            play_cnt     = '0;
            status_q.delete();
            mismatches   = 0;
            toggles_seen = 0;
            done_seen    = 0;
            in_flight   <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SLOW_PERIOD: timing.slow_period = cfg_data;
                    CFG_MID_PERIOD:  timing.mid_period  = cfg_data;
                    CFG_FAST_PERIOD: timing.fast_period = cfg_data;
                    CFG_DASH_TIME:   timing.dash_time   = cfg_data;
                    CFG_DOT_TIME:    timing.dot_time    = cfg_data;
                    CFG_GAP_CYCLE:   timing.gap_cycle   = cfg_data;
                    CFG_ACTIVE_LOW:  timing.active_low  = cfg_data[0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                want = predict_status({req.req_type, req.mode_code, req.duration,
                                       req.count, req.symbol_index, req.symbol_code,
                                       req.pattern_len});
                toggles_seen += int'(want.toggled);
                done_seen    += int'(want.sequence_done);
                status_q.push_back(want);
            end
            if (rsp.valid && rsp.ready)
            begin
                got = {rsp.pin_level, rsp.led_lit, rsp.toggled, rsp.sequence_done,
                       rsp.mode_now};
                if (status_q.size() == 0)
                begin
                    $error("status transaction with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = status_q.pop_front();
                    if (got.pin_level !== want.pin_level)
                    begin
                        $error("pin_level: expected %0d, actual %0d",
                               want.pin_level, got.pin_level);
                        mismatches++;
                    end
                    if (got.led_lit !== want.led_lit)
                    begin
                        $error("led_lit: expected %0d, actual %0d",
                               want.led_lit, got.led_lit);
                        mismatches++;
                    end
                    if (got.toggled !== want.toggled)
                    begin
                        $error("toggled: expected %0d, actual %0d",
                               want.toggled, got.toggled);
                        mismatches++;
                    end
                    if (got.sequence_done !== want.sequence_done)
                    begin
                        $error("sequence_done: expected %0d, actual %0d",
                               want.sequence_done, got.sequence_done);
                        mismatches++;
                    end
                    if (got.mode_now !== want.mode_now)
                    begin
                        $error("mode_now: expected %0d, actual %0d",
                               want.mode_now, got.mode_now);
                        mismatches++;
                    end
                end
            end
            in_flight <= status_q.size();
        end
    end

endmodule

### bench/tb_led_blink_pattern_sequencer_top.sv
// ============================================================================
// tb_led_blink_pattern_sequencer_top
// Drives ticks and commands into the LED sequencer under several timing and
// polarity settings: a directed opening, then random traffic built mostly of
// blink, counted blink and pattern runs fed by ticks, with random stalls on
// both channels. The checker beside the block predicts and compares.
// ============================================================================
module tb_led_blink_pattern_sequencer_top;
    import lbps_pkg::*;

    localparam int RANDOM_ITEMS   = 1300;
    localparam int PHASES         = 6;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    mismatches;
    int                    in_flight;
    int                    toggles_seen;
    int                    done_seen;
    int                    items_sent;
    int                    quiet_cycles = 0;
    int                    sym_prefix;
    logic [SYM_SLOTS-1:0]  sym_written;
    logic                  calm;

    lbps_req_if req ();
    lbps_rsp_if rsp ();

    led_blink_pattern_sequencer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lbps_sequencer_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .in_flight    (in_flight),
        .toggles_seen (toggles_seen),
        .done_seen    (done_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp.ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one request transaction; valid is left high so back-to-back items need no gap
    task automatic send_item(input logic [REQ_TYPE_W-1:0] kind,
                             input logic [MODE_W-1:0]     mode,
                             input logic [DUR_W-1:0]      dur,
                             input logic [COUNT_W-1:0]    cnt,
                             input logic [SYM_IDX_W-1:0]  idx,
                             input logic [SYM_CODE_W-1:0] code,
                             input logic [PLEN_W-1:0]     plen);
        if (!calm && $urandom_range(99) < 30)
        begin
            req.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 30);
        end
        req.valid        <= 1'b1;
        req.req_type     <= kind;
        req.mode_code    <= mode;
        req.duration     <= dur;
        req.count        <= cnt;
        req.symbol_index <= idx;
        req.symbol_code  <= code;
        req.pattern_len  <= plen;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        items_sent++;
        if (kind == REQ_WRITE_SYMBOL)
        begin
            sym_written[idx] = 1'b1;
            while (sym_prefix < SYM_SLOTS && sym_written[sym_prefix[SYM_IDX_W-1:0]])
                sym_prefix++;
        end
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
    endtask

    task automatic load_config(input cfg_t c);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SLOW_PERIOD;
        cfg_data  <= c.slow_period;
        @(posedge clk);
        cfg_index <= CFG_MID_PERIOD;
        cfg_data  <= c.mid_period;
        @(posedge clk);
        cfg_index <= CFG_FAST_PERIOD;
        cfg_data  <= c.fast_period;
        @(posedge clk);
        cfg_index <= CFG_DASH_TIME;
        cfg_data  <= c.dash_time;
        @(posedge clk);
        cfg_index <= CFG_DOT_TIME;
        cfg_data  <= c.dot_time;
        @(posedge clk);
        cfg_index <= CFG_GAP_CYCLE;
        cfg_data  <= c.gap_cycle;
        @(posedge clk);
        cfg_index <= CFG_ACTIVE_LOW;
        cfg_data  <= {15'd0, c.active_low};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // short periods keep blinks and patterns moving; one phase at each extreme
    function automatic cfg_t phase_cfg(int ph);
        cfg_t c;
        case (ph)
            0:       c = {16'd4, 16'd3, 16'd2, 16'd3, 16'd1, 16'd1, 1'b0};
            1:       c = {16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 1'b1};
            3:       c = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0};
            default:
            begin
                c.slow_period = PERIOD_W'($urandom_range(1, 8));
                c.mid_period  = PERIOD_W'($urandom_range(1, 6));
                c.fast_period = PERIOD_W'($urandom_range(1, 4));
                c.dash_time   = PERIOD_W'($urandom_range(1, 6));
                c.dot_time    = PERIOD_W'($urandom_range(1, 4));
                c.gap_cycle   = PERIOD_W'($urandom_range(1, 4));
                c.active_low  = 1'($urandom_range(1));
            end
        endcase
        return c;
    endfunction

    initial
    begin
        int                    pick;
        logic [MODE_W-1:0]     r_mode;
        logic [DUR_W-1:0]      r_dur;
        logic [COUNT_W-1:0]    r_cnt;
        logic [SYM_IDX_W-1:0]  r_idx;
        logic [SYM_CODE_W-1:0] r_code;
        logic [PLEN_W-1:0]     r_plen;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= CFG_SLOW_PERIOD;
        cfg_data         <= '0;
        req.valid        <= 1'b0;
        req.req_type     <= REQ_TICK;
        req.mode_code    <= MODE_OFF;
        req.duration     <= '0;
        req.count        <= '0;
        req.symbol_index <= '0;
        req.symbol_code  <= SYM_GAP;
        req.pattern_len  <= '0;
        calm             <= 1'b0;
        items_sent        = 0;
        sym_prefix        = 0;
        sym_written       = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_config(phase_cfg(0));

        // directed opening
        send_item(REQ_TICK, MODE_OFF, '0, '0, '0, SYM_GAP, '0);
        send_item(REQ_WRITE_SYMBOL, MODE_OFF, '0, '0, 4'd0, SYM_DASH, '0);
        send_item(REQ_WRITE_SYMBOL, MODE_OFF, '0, '0, 4'd1, SYM_DOT, '0);
        send_item(REQ_WRITE_SYMBOL, MODE_OFF, '0, '0, 4'd2, SYM_GAP, '0);
        send_item(REQ_WRITE_SYMBOL, MODE_OFF, '0, '0, 4'd3, SYM_DOT, '0);
        send_item(REQ_SET_MODE, MODE_ON, '0, '0, '0, SYM_GAP, '0);
        send_item(REQ_SET_MODE, MODE_OFF, '0, '0, '0, SYM_GAP, '0);
        send_item(REQ_SET_MODE, 3'd7, '0, '0, '0, SYM_GAP, '0);
        send_item(REQ_TICK, MODE_OFF, '0, '0, '0, SYM_GAP, '0);
        send_item(REQ_TICK, MODE_OFF, '0, '0, '0, SYM_GAP, '0);
        send_item(REQ_DELAY_MODE, MODE_MID, 32'd2, '0, '0, SYM_GAP, '0);
        send_item(REQ_DELAY_MODE, MODE_SLOW, 32'd1, '0, '0, SYM_GAP, '0);
        send_item(REQ_TICK, MODE_OFF, '0, '0, '0, SYM_GAP, '0);
        send_item(REQ_DELAY_MODE, MODE_OFF, 32'hFFFF_FFFF, 8'hFF, 4'hF, SYM_DASH, 5'd16);
        send_item(REQ_TICK, 3'd7, 32'hFFFF_FFFF, 8'hFF, 4'hF, SYM_DASH, 5'd16);
        send_item(REQ_COUNTED, MODE_OFF, 32'd1, 8'd2, '0, SYM_GAP, '0);
        repeat (4) send_item(REQ_TICK, MODE_OFF, '0, '0, '0, SYM_GAP, '0);
        send_item(REQ_START_PATTERN, MODE_OFF, '0, 8'd1, '0, SYM_GAP, 5'd4);
        repeat (5) send_item(REQ_TICK, MODE_OFF, '0, '0, '0, SYM_GAP, '0);
        send_item(REQ_START_PATTERN, MODE_OFF, '0, 8'd0, '0, SYM_GAP, 5'd0);
        send_item(REQ_COUNTED, MODE_OFF, 32'd0, 8'hFF, '0, SYM_GAP, '0);
        send_item(REQ_TICK, MODE_OFF, '0, '0, '0, SYM_GAP, '0);
        wait_drained();

        for (int ph = 1; ph <= PHASES; ph++)
        begin
            calm <= (ph == 2);
            load_config(phase_cfg(ph));
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                pick   = $urandom_range(99);
                r_mode = MODE_W'($urandom_range(7));
                r_dur  = $urandom;
                r_cnt  = COUNT_W'($urandom);
                r_idx  = SYM_IDX_W'($urandom);
                r_code = SYM_CODE_W'($urandom_range(2));
                r_plen = PLEN_W'($urandom_range(16));
                if (pick < 55)
                    send_item(REQ_TICK, r_mode, r_dur, r_cnt, r_idx, r_code, r_plen);
                else if (pick < 65)
                    send_item(REQ_SET_MODE, r_mode, r_dur, r_cnt, r_idx, r_code, r_plen);
                else if (pick < 72)
                begin
                    if ($urandom_range(9) != 0)
                        r_dur = $urandom_range(12);
                    send_item(REQ_DELAY_MODE, r_mode, r_dur, r_cnt, r_idx, r_code, r_plen);
                end
                else if (pick < 80)
                begin
                    if ($urandom_range(19) != 0)
                        r_dur = $urandom_range(6);
                    if ($urandom_range(19) != 0)
                        r_cnt = COUNT_W'($urandom_range(8));
                    send_item(REQ_COUNTED, r_mode, r_dur, r_cnt, r_idx, r_code, r_plen);
                end
                else if (pick < 90)
                begin
                    if ($urandom_range(19) != 0)
                        r_cnt = COUNT_W'($urandom_range(3));
                    // lengths past the store depth only once every slot holds a symbol
                    if (sym_prefix == SYM_SLOTS)
                        r_plen = PLEN_W'($urandom_range(31));
                    else
                        r_plen = PLEN_W'($urandom_range(sym_prefix));
                    send_item(REQ_START_PATTERN, r_mode, r_dur, r_cnt, r_idx, r_code,
                              r_plen);
                end
                else
                begin
                    r_idx = SYM_IDX_W'($urandom_range(15));
                    send_item(REQ_WRITE_SYMBOL, r_mode, r_dur, r_cnt, r_idx, r_code,
                              r_plen);
                end
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d items over %0d timing settings, all symbol slots %s.",
                 items_sent, PHASES + 1, (sym_prefix == SYM_SLOTS) ? "filled" : "not filled");
        $display("Predicted %0d toggles and %0d finished sequences; %0d mismatches.",
                 toggles_seen, done_seen, mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
